/* rtl/kli_pkg.sv */
// ----------------------------------------------------------------------------
// Keyframe linear interpolator package
// Shared sizes, operation and status codes, the keyframe entry layout and the
// sequencer states of the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

	// Track depth and the fraction width of the interpolation factor.
	localparam int MAX_KEYS  = 64;
	localparam int FRAC_BITS = 16;

	// Field widths.
	localparam int TICK_W = 16;
	localparam int VEC_W  = 32;
	localparam int SEC_W  = 32;
	localparam int TPS_W  = 32;

	// The time product is Q32.32: both factors carry 16 fraction bits.
	localparam int TIME_W  = SEC_W + TPS_W;
	localparam int TFRAC_W = 32;

	// Derived counter and address widths.
	localparam int ADDR_W = $clog2(MAX_KEYS);
	localparam int CNT_W  = $clog2(MAX_KEYS + 1);
	localparam int DIVC_W = $clog2(FRAC_BITS);

	// Product of a 33-bit signed difference and an unsigned factor.
	localparam int PROD_W = VEC_W + 1 + FRAC_BITS + 1;

	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(32'h0001_0000);

	localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
	localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;

	// Status codes of a result transaction.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Vector component selected by the shared multiplier.
	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Y = 2'd1;
	localparam logic [1:0] COMP_Z = 2'd2;

	// One keyframe as it is held in the track memory.
	typedef struct packed {
		logic        [TICK_W-1:0] tick;
		logic signed [VEC_W-1:0]  x;
		logic signed [VEC_W-1:0]  y;
		logic signed [VEC_W-1:0]  z;
	} key_t;

	localparam int KEY_W = $bits(key_t);

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SCAN,
		S_DIV,
		S_MULC,
		S_ADDC,
		S_OUT
	} state_t;

endpackage

/* rtl/kli_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address.
// ----------------------------------------------------------------------------
module kli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/keyframe_linear_interpolator_core.sv */
// ----------------------------------------------------------------------------
// Keyframe linear interpolator core
// From accept to out_valid: append, clear and an empty-track sample go to S_OUT.
// A sample on a filled track computes the time product, then searches 1 to MAX_KEYS
// keyframes, and an interpolating one then divides, multiplies and adds per component.
// One item at a time: the search reads one entry per cycle from the track memory,
// the factor takes one quotient bit per cycle and one multiplier serves x, y and z.
// arst_n empties the track, sets ticks_per_second to 1.0 and drops a held result.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_core
	import kli_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [TPS_W-1:0]         cfg_data,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               operation,
	input  logic [TICK_W-1:0]        key_tick,
	input  logic signed [VEC_W-1:0]  key_x,
	input  logic signed [VEC_W-1:0]  key_y,
	input  logic signed [VEC_W-1:0]  key_z,
	input  logic [SEC_W-1:0]         sample_seconds,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic signed [VEC_W-1:0]  out_x,
	output logic signed [VEC_W-1:0]  out_y,
	output logic signed [VEC_W-1:0]  out_z
);

	// Control state.
	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        key_count_q;
	logic [TPS_W-1:0]        tps_q;
	logic [ADDR_W-1:0]       scan_idx_q;
	logic [DIVC_W-1:0]       div_cnt_q;
	logic [1:0]              comp_q;
	logic                    out_valid_q;

	// Datapath registers.
	logic [SEC_W-1:0]        sec_q;
	logic [TIME_W-1:0]       time_q;
	key_t                    prev_q;
	key_t                    end_q;
	logic [TICK_W-1:0]       rem_q;
	logic [TICK_W-1:0]       dvs_q;
	logic [FRAC_BITS-1:0]    low_q;
	logic [FRAC_BITS-1:0]    quo_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [1:0]              res_status_q;
	logic signed [VEC_W-1:0] res_x_q, res_y_q, res_z_q;
	logic [1:0]              out_status_q;
	logic signed [VEC_W-1:0] out_x_q, out_y_q, out_z_q;

	// Memory ports.
	logic                    mem_wr_en;
	logic [ADDR_W-1:0]       mem_wr_addr;
	logic [KEY_W-1:0]        mem_wr_data;
	logic                    mem_rd_en;
	logic [ADDR_W-1:0]       mem_rd_addr;
	logic [KEY_W-1:0]        mem_rd_data;
	key_t                    rd_key;
	key_t                    wr_key;

	// Combinational helpers.
	logic                    in_acc;
	logic                    key_full;
	logic                    out_free;
	logic                    out_load;
	logic [TIME_W-TFRAC_W-1:0] time_hi;
	logic                    scan_first;
	logic                    scan_last;
	logic                    scan_lt;
	logic                    scan_interp;
	logic                    scan_sel;
	logic [TICK_W:0]         div_trial;
	logic                    div_ge;
	logic                    div_last;
	logic signed [VEC_W-1:0] start_c, end_c;
	logic signed [VEC_W:0]   diff_c;
	logic signed [FRAC_BITS:0] frac_c;
	logic signed [PROD_W-1:0] mul_c;
	logic signed [PROD_W-1:0] sum_c;
	logic signed [VEC_W-1:0] sat_c;

	// Track memory: one keyframe per entry.
	kli_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_KEYS)
	) u_track_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	assign rd_key = mem_rd_data;

	// Handshake and status terms.
	assign in_acc   = in_valid && !in_stall;
	assign key_full = (key_count_q == CNT_W'(MAX_KEYS));
	assign out_free = !out_valid_q || !out_stall;

	// Search decisions on the entry that the memory returns this cycle.
	assign time_hi     = time_q[TIME_W-1:TFRAC_W];
	assign scan_first  = (scan_idx_q == '0);
	assign scan_last   = (CNT_W'(scan_idx_q) == key_count_q - CNT_W'(1));
	assign scan_lt     = (time_hi < (TIME_W-TFRAC_W)'(rd_key.tick));
	assign scan_interp = !scan_first && scan_lt;
	assign scan_sel    = (scan_first && (scan_lt || scan_last)) ||
	                     (!scan_first && !scan_lt && scan_last);

	// One restoring division step per cycle for the interpolation factor.
	assign div_trial = {rem_q, low_q[FRAC_BITS-1]};
	assign div_ge    = (div_trial >= {1'b0, dvs_q});
	assign div_last  = (div_cnt_q == DIVC_W'(FRAC_BITS - 1));

	// Component selection for the shared multiplier and adder.
	always_comb begin
		case (comp_q)
			COMP_X: begin
				start_c = prev_q.x;
				end_c   = end_q.x;
			end
			COMP_Y: begin
				start_c = prev_q.y;
				end_c   = end_q.y;
			end
			default: begin
				start_c = prev_q.z;
				end_c   = end_q.z;
			end
		endcase
	end

	// Difference times factor, then start plus the floored quotient.
	assign diff_c = {end_c[VEC_W-1], end_c} - {start_c[VEC_W-1], start_c};
	assign frac_c = {1'b0, quo_q};
	assign mul_c  = diff_c * frac_c;
	assign sum_c  = PROD_W'(start_c) + (prod_q >>> FRAC_BITS);

	// Saturation to the signed vector range.
	always_comb begin
		if ((sum_c[PROD_W-1:VEC_W-1] == '0) || (sum_c[PROD_W-1:VEC_W-1] == '1)) begin
			sat_c = sum_c[VEC_W-1:0];
		end else if (sum_c[PROD_W-1]) begin
			sat_c = VEC_MIN;
		end else begin
			sat_c = VEC_MAX;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if ((operation == OP_SAMPLE) && (key_count_q != '0)) begin
						state_d = S_MUL;
					end else begin
						state_d = S_OUT;
					end
				end
			end
			S_MUL: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_interp) begin
					state_d = S_DIV;
				end else if (scan_sel) begin
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				if (div_last) begin
					state_d = S_MULC;
				end
			end
			S_MULC: begin
				state_d = S_ADDC;
			end
			S_ADDC: begin
				if (comp_q == COMP_Z) begin
					state_d = S_OUT;
				end else begin
					state_d = S_MULC;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State machine outputs.
	always_comb begin
		in_stall    = 1'b1;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		out_load    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_MUL: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = '0;
			end
			S_SCAN: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = scan_idx_q + ADDR_W'(1);
			end
			S_OUT: begin
				out_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Append writes the keyframe at the end of the track.
	assign wr_key.tick = key_tick;
	assign wr_key.x    = key_x;
	assign wr_key.y    = key_y;
	assign wr_key.z    = key_z;
	assign mem_wr_data = wr_key;
	assign mem_wr_addr = key_count_q[ADDR_W-1:0];
	assign mem_wr_en   = in_acc && (operation == OP_APPEND) && !key_full;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_count_q <= '0;
			tps_q       <= TPS_RESET;
			scan_idx_q  <= '0;
			div_cnt_q   <= '0;
			comp_q      <= COMP_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				tps_q <= cfg_data;
			end

			if (in_acc) begin
				if (operation == OP_APPEND && !key_full) begin
					key_count_q <= key_count_q + CNT_W'(1);
				end else if (operation == OP_CLEAR) begin
					key_count_q <= '0;
				end
				scan_idx_q <= '0;
			end

			if (state_q == S_SCAN && !scan_interp && !scan_sel) begin
				scan_idx_q <= scan_idx_q + ADDR_W'(1);
			end

			if (state_q == S_SCAN) begin
				div_cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + DIVC_W'(1);
			end

			if (state_q == S_DIV) begin
				comp_q <= COMP_X;
			end else if (state_q == S_ADDC) begin
				comp_q <= comp_q + 2'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					sec_q        <= sample_seconds;
					res_status_q <= ST_OK;
					res_x_q      <= '0;
					res_y_q      <= '0;
					res_z_q      <= '0;
					case (operation)
						OP_APPEND: begin
							if (key_full) begin
								res_status_q <= ST_FULL;
							end
						end
						OP_SAMPLE: begin
							if (key_count_q == '0) begin
								res_status_q <= ST_EMPTY;
							end
						end
						default: begin
							res_status_q <= ST_OK;
						end
					endcase
				end
			end
			S_MUL: begin
				time_q <= TIME_W'(sec_q) * TIME_W'(tps_q);
			end
			S_SCAN: begin
				if (scan_interp) begin
					end_q <= rd_key;
					rem_q <= time_hi[TICK_W-1:0] - prev_q.tick;
					dvs_q <= rd_key.tick - prev_q.tick;
					low_q <= time_q[TFRAC_W-1 -: FRAC_BITS];
				end else if (scan_sel) begin
					res_x_q <= rd_key.x;
					res_y_q <= rd_key.y;
					res_z_q <= rd_key.z;
				end else begin
					prev_q <= rd_key;
				end
			end
			S_DIV: begin
				if (div_ge) begin
					rem_q <= TICK_W'(div_trial - {1'b0, dvs_q});
				end else begin
					rem_q <= div_trial[TICK_W-1:0];
				end
				low_q <= {low_q[FRAC_BITS-2:0], 1'b0};
				quo_q <= {quo_q[FRAC_BITS-2:0], div_ge};
			end
			S_MULC: begin
				prod_q <= mul_c;
			end
			S_ADDC: begin
				case (comp_q)
					COMP_X:  res_x_q <= sat_c;
					COMP_Y:  res_y_q <= sat_c;
					default: res_z_q <= sat_c;
				endcase
			end
			S_OUT: begin
				if (out_load) begin
					out_status_q <= res_status_q;
					out_x_q      <= res_x_q;
					out_y_q      <= res_y_q;
					out_z_q      <= res_z_q;
				end
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	// Ports.
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

	// The track never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= CNT_W'(MAX_KEYS))
		else $error("Key count exceeds the track depth.");

	// The search only reads entries that hold keyframes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CNT_W'(scan_idx_q) < key_count_q))
		else $error("Search reads past the end of the track.");

	// The partial remainder stays below the segment length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dvs_q))
		else $error("Division remainder is not below the divisor.");

	// An append to a full track leaves the key count alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (operation == OP_APPEND) && key_full) |=> key_full)
		else $error("Append to a full track changed the key count.");

	// A result only becomes visible from the output state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("Output valid rose outside the output state.");

endmodule
